/* src/assert_macros.svh */
// Assertion macros used by the datapath RTL file of the matching block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When cond holds at a clock edge, expr must hold at the same edge.
`define ZF_ASSERT_IMP(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// When cond holds at a clock edge, expr must hold at the next edge.
`define ZF_ASSERT_NXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ZF_ASSERT_IMP(label, clk, rstn, cond, expr)
`define ZF_ASSERT_NXT(label, clk, rstn, cond, expr)

`endif

`endif

/* src/zfdm_pkg.sv */
package zfdm_pkg;

    // Fixed field widths.
    localparam int ORDER_W = 7;
    localparam int OUT_W = 6;
    localparam int MAX_ORDER_DEF = 64;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd64;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIAG_RD,
        ST_DIAG_CHK,
        ST_SCAN,
        ST_FETCH,
        ST_MASK,
        ST_FIND,
        ST_POP_RD,
        ST_POP_LD,
        ST_PUSH,
        ST_AUG_RD,
        ST_AUG_WR,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_SING,
        ST_CLEAR
    } state_t;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD_WR,
        OP_DIAG_RD,
        OP_DIAG_CHK,
        OP_CLR_C,
        OP_NEXT,
        OP_SEARCH_START,
        OP_FETCH,
        OP_MASK,
        OP_FIND,
        OP_POP_RD,
        OP_POP_LD,
        OP_PUSH,
        OP_AUG_RD,
        OP_AUG_WR,
        OP_OUT_RD,
        OP_OUT_LD,
        OP_SINGULAR,
        OP_CLEAR
    } op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic any_seen;
        logic c_done;
        logic c_last;
        logic col_matched;
        logic cand_zero;
        logic row_free;
        logic sp_one;
        logic k_zero;
        logic out_free;
    } stat_t;

endpackage

/* src/zfdm_ctrl.sv */
module zfdm_ctrl import zfdm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output op_t   op
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!stat.last) state_next = ST_IDLE;
                else if (stat.any_seen) state_next = ST_DIAG_RD;
                else state_next = ST_OUT_RD;
            end
            ST_DIAG_RD: begin
                state_next = stat.c_done ? ST_SCAN : ST_DIAG_CHK;
            end
            ST_DIAG_CHK: state_next = ST_DIAG_RD;
            ST_SCAN: begin
                if (stat.c_done) state_next = ST_OUT_RD;
                else if (!stat.col_matched) state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_MASK;
            ST_MASK: state_next = ST_FIND;
            ST_FIND: begin
                if (stat.cand_zero) begin
                    state_next = stat.sp_one ? ST_SING : ST_POP_RD;
                end else if (!stat.row_free) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = stat.sp_one ? ST_NEXT : ST_AUG_RD;
                end
            end
            ST_POP_RD: state_next = ST_POP_LD;
            ST_POP_LD: state_next = ST_FETCH;
            ST_PUSH: state_next = ST_FETCH;
            ST_AUG_RD: state_next = ST_AUG_WR;
            ST_AUG_WR: state_next = stat.k_zero ? ST_NEXT : ST_AUG_RD;
            ST_NEXT: state_next = ST_SCAN;
            ST_OUT_RD: state_next = ST_OUT_LD;
            ST_OUT_LD: begin
                if (stat.out_free) state_next = stat.c_last ? ST_CLEAR : ST_OUT_RD;
            end
            ST_SING: begin
                if (stat.out_free) state_next = ST_CLEAR;
            end
            ST_CLEAR: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        op = OP_NONE;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) op = OP_ACCEPT;
            end
            ST_LOAD: op = OP_LOAD_WR;
            ST_DIAG_RD: op = stat.c_done ? OP_CLR_C : OP_DIAG_RD;
            ST_DIAG_CHK: op = OP_DIAG_CHK;
            ST_SCAN: begin
                if (stat.c_done) op = OP_CLR_C;
                else if (stat.col_matched) op = OP_NEXT;
                else op = OP_SEARCH_START;
            end
            ST_FETCH: op = OP_FETCH;
            ST_MASK: op = OP_MASK;
            ST_FIND: op = OP_FIND;
            ST_POP_RD: op = OP_POP_RD;
            ST_POP_LD: op = OP_POP_LD;
            ST_PUSH: op = OP_PUSH;
            ST_AUG_RD: op = OP_AUG_RD;
            ST_AUG_WR: op = OP_AUG_WR;
            ST_NEXT: op = OP_NEXT;
            ST_OUT_RD: op = OP_OUT_RD;
            ST_OUT_LD: begin
                if (stat.out_free) op = OP_OUT_LD;
            end
            ST_SING: begin
                if (stat.out_free) op = OP_SINGULAR;
            end
            ST_CLEAR: op = OP_CLEAR;
            default: op = OP_NONE;
        endcase
    end

endmodule

/* src/zfdm_datapath.sv */
`include "assert_macros.svh"

module zfdm_datapath import zfdm_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  op_t                op,
    output stat_t              stat,
    input  logic [ORDER_W-1:0] s_entry_row,
    input  logic [ORDER_W-1:0] s_entry_col,
    input  logic               s_entry_nonzero,
    input  logic               s_entry_present,
    input  logic               s_last_entry,
    input  logic               cfg_wr_en,
    input  logic [ORDER_W-1:0] cfg_wr_data,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [OUT_W-1:0]   m_column_index,
    output logic [OUT_W-1:0]   m_matched_row,
    output logic               m_singular,
    output logic               m_last_result
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int STK_W = IDX_W + ORDER_W;

    // Configuration and the order in force.
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] n;

    // Captured request.
    logic [ORDER_W-1:0] ent_row_reg;
    logic [ORDER_W-1:0] ent_col_reg;
    logic               ent_ok_reg;
    logic               last_reg;
    logic               any_seen_reg;

    // Bitmap memory, one word of row bits per column, with per-column valid flags.
    logic [MAX_ORDER-1:0] bm_mem [MAX_ORDER];
    logic [MAX_ORDER-1:0] bm_vld_reg;
    logic [MAX_ORDER-1:0] bm_rd_reg;
    logic                 bm_rd_vld_reg;
    logic [IDX_W-1:0]     bm_raddr;
    logic [MAX_ORDER-1:0] bm_eff;

    // Matching memories and their matched flags.
    logic [IDX_W-1:0]     rowcol_mem [MAX_ORDER];
    logic [IDX_W-1:0]     colrow_mem [MAX_ORDER];
    logic [IDX_W-1:0]     rowcol_rd_reg;
    logic [IDX_W-1:0]     colrow_rd_reg;
    logic [MAX_ORDER-1:0] col_match_reg;
    logic [MAX_ORDER-1:0] row_match_reg;

    // Search stack holds the frames below the top frame.
    logic [STK_W-1:0]   stk_mem [MAX_ORDER];
    logic [STK_W-1:0]   stk_rd_reg;
    logic [ORDER_W-1:0] stk_raddr;
    logic [ORDER_W-1:0] sp_m1;
    logic [ORDER_W-1:0] k_m1;

    // Search state.
    logic [ORDER_W-1:0]   c_reg;
    logic [ORDER_W-1:0]   sp_reg;
    logic [ORDER_W-1:0]   k_reg;
    logic [IDX_W-1:0]     cur_col_reg;
    logic [ORDER_W-1:0]   cur_r_reg;
    logic [MAX_ORDER-1:0] visited_reg;
    logic [MAX_ORDER-1:0] cand_reg;
    logic [MAX_ORDER-1:0] cand_low;
    logic [IDX_W-1:0]     found_idx;
    logic [IDX_W-1:0]     c_idx;
    logic [IDX_W-1:0]     aug_col;
    logic [IDX_W-1:0]     aug_row;

    // Output register.
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_column_reg;
    logic [OUT_W-1:0]   m_row_reg;
    logic               m_singular_reg;
    logic               m_last_reg;

    // Rows from r up to but not including n.
    function automatic logic [MAX_ORDER-1:0] row_window(
        input logic [ORDER_W-1:0] r,
        input logic [ORDER_W-1:0] lim
    );
        logic [MAX_ORDER-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            m[i] = (ORDER_W'(i) >= r) && (ORDER_W'(i) < lim);
        end
        return m;
    endfunction

    // Order clamped to the supported range.
    always_comb begin
        if (order_reg == '0) n = ORDER_W'(1);
        else if (order_reg > ORDER_W'(MAX_ORDER)) n = ORDER_W'(MAX_ORDER);
        else n = order_reg;
    end

    assign c_idx = c_reg[IDX_W-1:0];
    assign bm_eff = bm_rd_vld_reg ? bm_rd_reg : '0;
    assign sp_m1 = sp_reg - ORDER_W'(1);
    assign k_m1 = k_reg - ORDER_W'(1);
    assign aug_col = stk_rd_reg[STK_W-1:ORDER_W];
    assign aug_row = IDX_W'(stk_rd_reg[ORDER_W-1:0] - ORDER_W'(1));

    // Lowest candidate row: isolate the lowest set bit, then encode it.
    assign cand_low = cand_reg & (~cand_reg + MAX_ORDER'(1));
    always_comb begin
        found_idx = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (cand_low[i]) found_idx = found_idx | IDX_W'(i);
        end
    end

    // Read address selection.
    always_comb begin
        case (op)
            OP_DIAG_RD: bm_raddr = c_idx;
            OP_FETCH: bm_raddr = cur_col_reg;
            default: bm_raddr = s_entry_col[IDX_W-1:0];
        endcase
        stk_raddr = (op == OP_AUG_RD) ? k_m1 : (sp_reg - ORDER_W'(2));
    end

    // Memory reads, registered.
    always_ff @(posedge aclk) begin
        bm_rd_reg <= bm_mem[bm_raddr];
        bm_rd_vld_reg <= bm_vld_reg[bm_raddr];
        rowcol_rd_reg <= rowcol_mem[c_idx];
        colrow_rd_reg <= colrow_mem[found_idx];
        stk_rd_reg <= stk_mem[stk_raddr[IDX_W-1:0]];
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD_WR: begin
                if (ent_ok_reg) begin
                    bm_mem[ent_col_reg[IDX_W-1:0]] <=
                        bm_eff | (MAX_ORDER'(1) << ent_row_reg[IDX_W-1:0]);
                end
            end
            OP_DIAG_CHK: begin
                if (bm_eff[c_idx]) begin
                    rowcol_mem[c_idx] <= c_idx;
                    colrow_mem[c_idx] <= c_idx;
                end
            end
            OP_FIND: begin
                if (cand_reg != '0 && !row_match_reg[found_idx]) begin
                    rowcol_mem[cur_col_reg] <= found_idx;
                    colrow_mem[found_idx] <= cur_col_reg;
                end
            end
            OP_PUSH: begin
                stk_mem[sp_m1[IDX_W-1:0]] <= {cur_col_reg, cur_r_reg};
            end
            OP_AUG_WR: begin
                rowcol_mem[aug_col] <= aug_row;
                colrow_mem[aug_row] <= aug_col;
            end
            default: ;
        endcase
    end

    // Payload registers of the search and the captured request.
    always_ff @(posedge aclk) begin
        case (op)
            OP_ACCEPT: begin
                ent_row_reg <= s_entry_row;
                ent_col_reg <= s_entry_col;
                ent_ok_reg <= s_entry_present && s_entry_nonzero &&
                              (s_entry_row < n) && (s_entry_col < n);
            end
            OP_SEARCH_START: begin
                cur_col_reg <= c_idx;
                cur_r_reg <= '0;
            end
            OP_MASK: begin
                cand_reg <= bm_eff & ~visited_reg & row_window(cur_r_reg, n);
            end
            OP_FIND: begin
                cur_r_reg <= ORDER_W'(found_idx) + ORDER_W'(1);
            end
            OP_POP_LD: begin
                cur_col_reg <= stk_rd_reg[STK_W-1:ORDER_W];
                cur_r_reg <= stk_rd_reg[ORDER_W-1:0];
            end
            OP_PUSH: begin
                cur_col_reg <= colrow_rd_reg;
                cur_r_reg <= '0;
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
            last_reg <= 1'b0;
            any_seen_reg <= 1'b0;
            bm_vld_reg <= '0;
            col_match_reg <= '0;
            row_match_reg <= '0;
            visited_reg <= '0;
            c_reg <= '0;
            sp_reg <= '0;
            k_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) order_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (op)
                OP_ACCEPT: begin
                    last_reg <= s_last_entry;
                    if (s_entry_present) any_seen_reg <= 1'b1;
                end
                OP_LOAD_WR: begin
                    c_reg <= '0;
                    if (ent_ok_reg) bm_vld_reg[ent_col_reg[IDX_W-1:0]] <= 1'b1;
                end
                OP_DIAG_CHK: begin
                    c_reg <= c_reg + ORDER_W'(1);
                    if (bm_eff[c_idx]) begin
                        col_match_reg[c_idx] <= 1'b1;
                        row_match_reg[c_idx] <= 1'b1;
                    end
                end
                OP_CLR_C: c_reg <= '0;
                OP_NEXT: c_reg <= c_reg + ORDER_W'(1);
                OP_SEARCH_START: begin
                    sp_reg <= ORDER_W'(1);
                    visited_reg <= '0;
                end
                OP_FIND: begin
                    if (cand_reg != '0) begin
                        visited_reg[found_idx] <= 1'b1;
                        if (!row_match_reg[found_idx]) begin
                            col_match_reg[cur_col_reg] <= 1'b1;
                            row_match_reg[found_idx] <= 1'b1;
                            k_reg <= sp_m1;
                        end
                    end
                end
                OP_POP_RD: sp_reg <= sp_m1;
                OP_PUSH: sp_reg <= sp_reg + ORDER_W'(1);
                OP_AUG_RD: k_reg <= k_m1;
                OP_OUT_LD: begin
                    m_valid_reg <= 1'b1;
                    c_reg <= c_reg + ORDER_W'(1);
                end
                OP_SINGULAR: m_valid_reg <= 1'b1;
                OP_CLEAR: begin
                    any_seen_reg <= 1'b0;
                    bm_vld_reg <= '0;
                    col_match_reg <= '0;
                    row_match_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (op == OP_OUT_LD) begin
            m_column_reg <= OUT_W'(c_idx);
            m_row_reg <= any_seen_reg ? OUT_W'(rowcol_rd_reg) : OUT_W'(c_idx);
            m_singular_reg <= 1'b0;
            m_last_reg <= (c_reg == n - ORDER_W'(1));
        end else if (op == OP_SINGULAR) begin
            m_column_reg <= '0;
            m_row_reg <= '0;
            m_singular_reg <= 1'b1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_column_index = m_column_reg;
    assign m_matched_row = m_row_reg;
    assign m_singular = m_singular_reg;
    assign m_last_result = m_last_reg;

    // Status to the controller.
    always_comb begin
        stat.last = last_reg;
        stat.any_seen = any_seen_reg;
        stat.c_done = (c_reg == n);
        stat.c_last = (c_reg == n - ORDER_W'(1));
        stat.col_matched = col_match_reg[c_idx];
        stat.cand_zero = (cand_reg == '0);
        stat.row_free = !row_match_reg[found_idx];
        stat.sp_one = (sp_reg == ORDER_W'(1));
        stat.k_zero = (k_reg == '0);
        stat.out_free = !m_valid_reg || m_ready;
    end

    // The stack never holds more frames than there are columns.
    `ZF_ASSERT_IMP(a_sp_bound, aclk, aresetn, 1'b1, sp_reg <= ORDER_W'(MAX_ORDER))
    // A singular result is the final one and names column zero.
    `ZF_ASSERT_IMP(a_singular_alone, aclk, aresetn, m_valid_reg && m_singular_reg, m_last_reg && m_column_reg == '0)
    // A row taken by the search is marked visited in the next cycle.
    `ZF_ASSERT_NXT(a_visit_mark, aclk, aresetn, op == OP_FIND && cand_reg != '0, visited_reg[$past(found_idx)])

endmodule

/* src/zero_free_diagonal_matching_top.sv */
// Zero-free diagonal matching. Requests carry (row, column, nonzero) entries of a square
// matrix of order cfg_wr_data (1 to MAX_ORDER); each entry is a read and a write of the
// column bitmap memory, and a new entry is accepted only once the last is written. The
// request with s_last_entry set starts the matching: a diagonal pass over the columns,
// then an augmenting-path search for each unmatched column, in which each row tried is
// fetched, masked and found and each stack frame on augment is read and its pair written,
// all through the one bitmap read port. Results follow one per column in ascending order,
// or a single result with m_singular set when no full matching exists. With no entry since
// the previous run the identity is returned. The store is emptied through valid flags after
// the results, so no clearing pass is needed. Write the order only while the block is idle.
module zero_free_diagonal_matching_top import zfdm_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ORDER_W-1:0] s_entry_row,
    input  logic [ORDER_W-1:0] s_entry_col,
    input  logic               s_entry_nonzero,
    input  logic               s_entry_present,
    input  logic               s_last_entry,
    input  logic               cfg_wr_en,
    input  logic [ORDER_W-1:0] cfg_wr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_column_index,
    output logic [OUT_W-1:0]   m_matched_row,
    output logic               m_singular,
    output logic               m_last_result
);

    op_t   op;
    stat_t stat;

    // Sequencer.
    zfdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .op      (op)
    );

    // Storage, search registers and result register.
    zfdm_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .stat            (stat),
        .s_entry_row     (s_entry_row),
        .s_entry_col     (s_entry_col),
        .s_entry_nonzero (s_entry_nonzero),
        .s_entry_present (s_entry_present),
        .s_last_entry    (s_last_entry),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_column_index  (m_column_index),
        .m_matched_row   (m_matched_row),
        .m_singular      (m_singular),
        .m_last_result   (m_last_result)
    );

endmodule
